### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define RPDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define RPDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rpdp_pkg.sv
// ----------------------------------------------------------------------------
// rpdp_pkg
// Constants and types of the radar point doppler projection.
// ----------------------------------------------------------------------------
package rpdp_pkg;

  localparam int MAX_STEPS = 24;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [31:0] GAIN_INV     = 32'd652032874;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // radial path: products, sums, square, then one stage per quotient bit
  localparam int QBITS         = 17;
  localparam int RADIAL_STAGES = 3 + QBITS;

  typedef enum logic [1:0] {
    REG_YAW      = 2'd0,
    REG_OFFSET_X = 2'd1,
    REG_OFFSET_Y = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [QBITS-1:0] q;
    logic             sgn;
    logic             nz;
  } rad_t;

endpackage

### design/radar_point_doppler_projection.sv
// ----------------------------------------------------------------------------
// radar_point_doppler_projection
// Doppler measurement row of one radar detection for ego-motion estimation.
// ----------------------------------------------------------------------------
// Takes one detection per clock. The vectoring and rotation CORDICs take one
// stage per step each, plus the unit vector and the offset product registers.
// The radial speed takes three stages for products, sums and the square, then
// one stage per quotient bit. A held output word stalls the whole pipeline and
// the input with it. Configure yaw and offsets only while the block is empty;
// cfg_ready is always high.
`include "assert_macros.svh"

module radar_point_doppler_projection #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] range_long,
  input  logic signed [15:0] range_lat,
  input  logic signed [15:0] speed_long,
  input  logic signed [15:0] speed_lat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] bearing_cos,
  output logic signed [15:0] bearing_sin,
  output logic signed [16:0] rotation_term,
  output logic signed [16:0] radial_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int LA  = 2 * CORDIC_STEPS + 2;
  localparam int LB  = rpdp_pkg::RADIAL_STAGES;
  localparam int LAT = (LA > LB) ? LA : LB;
  localparam int DA  = LAT - LA;
  localparam int DB  = LAT - LB;

  logic        [15:0] mount_yaw;
  logic signed [15:0] mount_offset_x;
  logic signed [15:0] mount_offset_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_yaw      <= '0;
      mount_offset_x <= '0;
      mount_offset_y <= '0;
    end else if (cfg_valid) begin
      case (rpdp_pkg::reg_index_t'(cfg_index))
        rpdp_pkg::REG_YAW:      mount_yaw      <= cfg_data;
        rpdp_pkg::REG_OFFSET_X: mount_offset_x <= cfg_data;
        rpdp_pkg::REG_OFFSET_Y: mount_offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output word is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic vld [LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) begin
        vld[k] <= vld[k-1];
      end
      out_valid <= vld[LAT-1];
    end
  end

  logic        [31:0] bearing;
  logic signed [15:0] c_rot;
  logic signed [15:0] s_rot;
  logic signed [31:0] prod_yc;
  logic signed [31:0] prod_xs;
  logic signed [15:0] c_al;
  logic signed [15:0] s_al;
  logic signed [31:0] prod_yc_al;
  logic signed [31:0] prod_xs_al;
  rpdp_pkg::rad_t     rad;
  rpdp_pkg::rad_t     rad_al;

  rpdp_vector #(.CORDIC_STEPS(CORDIC_STEPS)) u_vector (
    .clk(clk), .en(en), .x(range_long), .y(range_lat), .z(bearing)
  );

  rpdp_rotate #(.CORDIC_STEPS(CORDIC_STEPS)) u_rotate (
    .clk(clk), .en(en), .th(bearing), .yaw(mount_yaw), .c(c_rot), .s(s_rot)
  );

  rpdp_rot_term u_rot_term (
    .clk(clk), .en(en), .c(c_rot), .s(s_rot),
    .offset_x(mount_offset_x), .offset_y(mount_offset_y),
    .prod_yc(prod_yc), .prod_xs(prod_xs)
  );

  rpdp_radial u_radial (
    .clk(clk), .en(en), .x(range_long), .y(range_lat),
    .vx(speed_long), .vy(speed_lat), .rad(rad)
  );

  rpdp_delay #(.DEPTH(DA + 1), .WIDTH(32)) u_dly_cs (
    .clk(clk), .en(en), .din({c_rot, s_rot}), .dout({c_al, s_al})
  );

  rpdp_delay #(.DEPTH(DA), .WIDTH(64)) u_dly_prod (
    .clk(clk), .en(en), .din({prod_yc, prod_xs}), .dout({prod_yc_al, prod_xs_al})
  );

  rpdp_delay #(.DEPTH(DB), .WIDTH($bits(rpdp_pkg::rad_t))) u_dly_rad (
    .clk(clk), .en(en), .din(rad), .dout(rad_al)
  );

  logic signed [32:0] rot_sum;
  logic signed [32:0] rot_rnd;
  logic signed [16:0] rot_next;
  logic signed [17:0] q_ext;
  logic signed [17:0] rad_val;
  logic signed [16:0] rad_next;

  always_comb begin
    rot_sum = {prod_xs_al[31], prod_xs_al} - {prod_yc_al[31], prod_yc_al};
    rot_rnd = (rot_sum + 33'sd8192) >>> 14;
    if (rot_rnd > 33'sd65535) begin
      rot_next = 17'sd65535;
    end else if (rot_rnd < -33'sd65536) begin
      rot_next = -17'sd65536;
    end else begin
      rot_next = rot_rnd[16:0];
    end
    q_ext = {1'b0, rad_al.q};
    if (!rad_al.nz) begin
      rad_val = '0;
    end else if (rad_al.sgn) begin
      rad_val = q_ext;
    end else begin
      rad_val = -q_ext;
    end
    rad_next = (rad_val > 18'sd65535) ? 17'sd65535 : rad_val[16:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing_cos   <= c_al;
      bearing_sin   <= s_al;
      rotation_term <= rot_next;
      radial_speed  <= rad_next;
    end
  end

  `RPDP_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(radial_speed) && $stable(rotation_term), "output word changed while stalled")
  `RPDP_ASSERT(a_cos_rng, out_valid |-> bearing_cos <= 16'sd16384 && bearing_cos >= -16'sd16384, "bearing_cos out of range")
  `RPDP_ASSERT(a_stall, !in_ready |-> out_valid && !out_ready, "input stalled without held output")
  `RPDP_ASSERT_ALWAYS(a_rst, rst |=> !out_valid, "output valid after reset")

endmodule

### design/rpdp_delay.sv
// ----------------------------------------------------------------------------
// rpdp_delay
// Enabled register delay line used to align the pipeline branches.
// ----------------------------------------------------------------------------
module rpdp_delay #(
  parameter int DEPTH = 1,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_regs
      logic [WIDTH-1:0] tap [DEPTH];
      always_ff @(posedge clk) begin
        if (en) begin
          tap[0] <= din;
          for (int k = 1; k < DEPTH; k++) begin
            tap[k] <= tap[k-1];
          end
        end
      end
      assign dout = tap[DEPTH-1];
    end
  endgenerate

endmodule

### design/rpdp_vector.sv
// ----------------------------------------------------------------------------
// rpdp_vector
// Pipelined vectoring CORDIC: bearing of (x,y), 2^32 units per turn.
// ----------------------------------------------------------------------------
module rpdp_vector #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic        [31:0] z
);

  localparam int VW = 35;

  logic signed [VW-1:0] xs [CORDIC_STEPS];
  logic signed [VW-1:0] ys [CORDIC_STEPS];
  logic        [31:0]   zs [CORDIC_STEPS];
  logic                 org [CORDIC_STEPS];

  logic signed [VW-1:0] x0;
  logic signed [VW-1:0] y0;
  logic signed [VW-1:0] xp;
  logic signed [VW-1:0] yp;
  logic        [31:0]   zp;

  always_comb begin
    x0 = {{3{x[15]}}, x, 16'h0000};
    y0 = {{3{y[15]}}, y, 16'h0000};
    if (x[15]) begin
      xp = -x0;
      yp = -y0;
      zp = rpdp_pkg::HALF_TURN;
    end else begin
      xp = x0;
      yp = y0;
      zp = '0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [VW-1:0] xi;
      logic signed [VW-1:0] yi;
      logic        [31:0]   zi;
      logic                 oi;
      if (i == 0) begin : g_first
        assign xi = xp;
        assign yi = yp;
        assign zi = zp;
        assign oi = (x == '0) && (y == '0);
      end else begin : g_next
        assign xi = xs[i-1];
        assign yi = ys[i-1];
        assign zi = zs[i-1];
        assign oi = org[i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          org[i] <= oi;
          if (!yi[VW-1]) begin
            xs[i] <= xi + (yi >>> i);
            ys[i] <= yi - (xi >>> i);
            zs[i] <= zi + rpdp_pkg::ATAN_TAB[i];
          end else begin
            xs[i] <= xi - (yi >>> i);
            ys[i] <= yi + (xi >>> i);
            zs[i] <= zi - rpdp_pkg::ATAN_TAB[i];
          end
        end
      end
    end
  endgenerate

  assign z = org[CORDIC_STEPS-1] ? '0 : zs[CORDIC_STEPS-1];

endmodule

### design/rpdp_rotate.sv
// ----------------------------------------------------------------------------
// rpdp_rotate
// Pipelined rotation CORDIC: cos and sin of bearing plus yaw, Q2.14.
// ----------------------------------------------------------------------------
module rpdp_rotate #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic        [31:0] th,
  input  logic        [15:0] yaw,
  output logic signed [15:0] c,
  output logic signed [15:0] s
);

  localparam int RW = 34;
  localparam logic signed [RW-1:0] LIM  = RW'(16384);
  localparam logic signed [RW-1:0] HALF = RW'(32768);

  logic signed [RW-1:0] xs  [CORDIC_STEPS];
  logic signed [RW-1:0] ys  [CORDIC_STEPS];
  logic signed [RW-1:0] zs  [CORDIC_STEPS];
  logic                 ngs [CORDIC_STEPS];

  logic        [31:0]   t;
  logic        [31:0]   tq;
  logic        [31:0]   tf;
  logic                 fold;
  logic signed [RW-1:0] z0;
  logic signed [RW-1:0] g;
  logic signed [RW-1:0] a0;

  always_comb begin
    t    = th + {yaw, 16'h0000};
    tq   = t + rpdp_pkg::QUARTER_TURN;
    fold = tq[31];
    tf   = fold ? (t ^ rpdp_pkg::HALF_TURN) : t;
    z0   = {{(RW-32){tf[31]}}, tf};
    g    = {{(RW-32){1'b0}}, rpdp_pkg::GAIN_INV};
    a0   = {{(RW-32){1'b0}}, rpdp_pkg::ATAN_TAB[0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ngs[0] <= fold;
      xs[0]  <= g;
      if (!z0[RW-1]) begin
        ys[0] <= g;
        zs[0] <= z0 - a0;
      end else begin
        ys[0] <= -g;
        zs[0] <= z0 + a0;
      end
    end
  end

  genvar i;
  generate
    for (i = 1; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [RW-1:0] ai;
      assign ai = {{(RW-32){1'b0}}, rpdp_pkg::ATAN_TAB[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          ngs[i] <= ngs[i-1];
          if (!zs[i-1][RW-1]) begin
            xs[i] <= xs[i-1] - (ys[i-1] >>> i);
            ys[i] <= ys[i-1] + (xs[i-1] >>> i);
            zs[i] <= zs[i-1] - ai;
          end else begin
            xs[i] <= xs[i-1] + (ys[i-1] >>> i);
            ys[i] <= ys[i-1] - (xs[i-1] >>> i);
            zs[i] <= zs[i-1] + ai;
          end
        end
      end
    end
  endgenerate

  logic signed [RW-1:0] xr;
  logic signed [RW-1:0] yr;
  logic signed [RW-1:0] xc;
  logic signed [RW-1:0] yc;
  logic signed [15:0]   c_next;
  logic signed [15:0]   s_next;

  always_comb begin
    xr = (xs[CORDIC_STEPS-1] + HALF) >>> 16;
    yr = (ys[CORDIC_STEPS-1] + HALF) >>> 16;
    xc = (xr > LIM) ? LIM : ((xr < -LIM) ? -LIM : xr);
    yc = (yr > LIM) ? LIM : ((yr < -LIM) ? -LIM : yr);
    c_next = ngs[CORDIC_STEPS-1] ? -xc[15:0] : xc[15:0];
    s_next = ngs[CORDIC_STEPS-1] ? -yc[15:0] : yc[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c <= c_next;
      s <= s_next;
    end
  end

endmodule

### design/rpdp_rot_term.sv
// ----------------------------------------------------------------------------
// rpdp_rot_term
// Products of the mounting offsets with the unit vector.
// ----------------------------------------------------------------------------
module rpdp_rot_term (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] c,
  input  logic signed [15:0] s,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  output logic signed [31:0] prod_yc,
  output logic signed [31:0] prod_xs
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_yc <= offset_y * c;
      prod_xs <= offset_x * s;
    end
  end

endmodule

### design/rpdp_radial.sv
// ----------------------------------------------------------------------------
// rpdp_radial
// Radial speed magnitude round(|v.r| / |r|), one quotient bit per stage.
// ----------------------------------------------------------------------------
module rpdp_radial (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] vx,
  input  logic signed [15:0] vy,
  output rpdp_pkg::rad_t     rad
);

  localparam int QB = rpdp_pkg::QBITS;
  localparam int SW = 70;

  // products
  logic signed [31:0] pvx;
  logic signed [31:0] pvy;
  logic signed [31:0] pxx;
  logic signed [31:0] pyy;

  always_ff @(posedge clk) begin
    if (en) begin
      pvx <= vx * x;
      pvy <= vy * y;
      pxx <= x * x;
      pyy <= y * y;
    end
  end

  // sums and magnitude
  logic signed [32:0] dot;
  logic        [32:0] dmag;
  logic        [31:0] d2;
  logic        [31:0] r2_2;
  logic               sgn2;
  logic               nz2;

  always_comb begin
    dot  = {pvx[31], pvx} + {pvy[31], pvy};
    dmag = dot[32] ? -dot : dot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2   <= dmag[31:0];
      r2_2 <= pxx + pyy;
      sgn2 <= dot[32];
      nz2  <= (dot != '0);
    end
  end

  // 4*d^2 and search seed: t = 2q-1 = -1
  logic [63:0]          dsq;
  logic signed [SW-1:0] rr3;
  logic        [31:0]   r2_3;
  logic                 sgn3;
  logic                 nz3;

  assign dsq = d2 * d2;

  always_ff @(posedge clk) begin
    if (en) begin
      rr3  <= {4'h0, dsq, 2'b00};
      r2_3 <= r2_2;
      sgn3 <= sgn2;
      nz3  <= nz2;
    end
  end

  logic [QB-1:0]        qs  [QB];
  logic signed [SW-1:0] ss  [QB];
  logic signed [SW-1:0] ps  [QB];
  logic signed [SW-1:0] rrs [QB];
  logic        [31:0]   r2s [QB];
  logic                 sgs [QB];
  logic                 nzs [QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_bit
      localparam int B = QB - 1 - k;
      logic [QB-1:0]        qi;
      logic signed [SW-1:0] si;
      logic signed [SW-1:0] pi;
      logic signed [SW-1:0] rri;
      logic        [31:0]   r2i;
      logic                 sgi;
      logic                 nzi;
      logic signed [SW-1:0] r2e;
      logic signed [SW-1:0] cand;
      logic signed [SW-1:0] pn;
      logic                 keep;
      if (k == 0) begin : g_first
        assign qi  = '0;
        assign si  = {{(SW-32){1'b0}}, r2_3};
        assign pi  = -{{(SW-32){1'b0}}, r2_3};
        assign rri = rr3;
        assign r2i = r2_3;
        assign sgi = sgn3;
        assign nzi = nz3;
      end else begin : g_next
        assign qi  = qs[k-1];
        assign si  = ss[k-1];
        assign pi  = ps[k-1];
        assign rri = rrs[k-1];
        assign r2i = r2s[k-1];
        assign sgi = sgs[k-1];
        assign nzi = nzs[k-1];
      end
      always_comb begin
        r2e  = {{(SW-32){1'b0}}, r2i};
        cand = si + (pi <<< (B + 2)) + (r2e <<< (2 * B + 2));
        pn   = pi + (r2e <<< (B + 1));
        keep = (cand <= rri) && ((B == QB - 1) || !qi[QB-1]);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rrs[k] <= rri;
          r2s[k] <= r2i;
          sgs[k] <= sgi;
          nzs[k] <= nzi;
          if (keep) begin
            qs[k] <= qi | (QB'(1) << B);
            ss[k] <= cand;
            ps[k] <= pn;
          end else begin
            qs[k] <= qi;
            ss[k] <= si;
            ps[k] <= pi;
          end
        end
      end
    end
  endgenerate

  assign rad.q   = qs[QB-1];
  assign rad.sgn = sgs[QB-1];
  assign rad.nz  = nzs[QB-1];

endmodule

### tb/tb_radar_point_doppler_projection.sv
// ----------------------------------------------------------------------------
// tb_radar_point_doppler_projection
// Self-checking bench for the doppler measurement row of one radar detection.
// ----------------------------------------------------------------------------
// Detections are queued by a stimulus process and driven by a clocked driver
// with random gaps. A clocked monitor stalls the output at random and checks
// every accepted word against a bit-accurate integer model of the CORDIC
// bearing, the rotational term and the rounded radial speed. The mounting
// registers are rewritten between phases while the pipeline is empty.
`timescale 1ns / 1ps

module tb_radar_point_doppler_projection;

  localparam int STEPS = 16;
  localparam int LATENCY = ((2 * STEPS + 2) > 20 ? (2 * STEPS + 2) : 20) + 1;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } detection_t;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic signed [16:0] rot;
    logic signed [16:0] rad;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] range_long = '0, range_lat = '0, speed_long = '0, speed_lat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] bearing_cos, bearing_sin;
  logic signed [16:0] rotation_term, radial_speed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = rpdp_pkg::REG_YAW;
  logic [15:0] cfg_data = '0;

  logic [15:0] yaw_reg = '0, offx_reg = '0, offy_reg = '0;
  detection_t pending_points[$];
  row_t expected_rows[$];
  int errors = 0;
  int rows_checked = 0;
  longint cycles = 0;
  bit hold_output = 1'b0;
  bit pause_driver = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  radar_point_doppler_projection #(.CORDIC_STEPS(STEPS)) DUT (.*);

  always #5 clk = ~clk;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] bearing_of(longint x, longint y);
    logic [31:0] z = '0;
    longint bx = x * 65536, by = y * 65536, dx, dy;
    if (x == 0 && y == 0) return '0;
    if (bx < 0) begin
      bx = -bx; by = -by; z = rpdp_pkg::HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = sra(by, i); dy = sra(bx, i);
      if (by >= 0) begin
        bx += dx; by -= dy; z += rpdp_pkg::ATAN_TAB[i];
      end else begin
        bx -= dx; by += dy; z -= rpdp_pkg::ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  // exact round(d / sqrt(r2)), d >= 0
  function automatic longint speed_quotient(longint d, longint r2);
    longint lo = 0, hi = 65536, q, t;
    logic [127:0] lhs, rhs;
    rhs = 128'(d) * 128'(4 * d);
    while (lo < hi) begin
      q = (lo + hi + 1) / 2;
      t = 2 * q - 1;
      lhs = 128'(t * t) * 128'(r2);
      if (lhs <= rhs) lo = q;
      else hi = q - 1;
    end
    return lo;
  endfunction

  function automatic row_t project(detection_t p);
    row_t r;
    longint x = p.x, y = p.y, vx = p.vx, vy = p.vy;
    longint cx = rpdp_pkg::GAIN_INV, cy = 0, z, dx, dy, c, s, rot, rad = 0, dot, r2, q;
    logic [31:0] th;
    bit flip = 1'b0;
    th = bearing_of(x, y) + {yaw_reg, 16'h0};
    if (32'(th + rpdp_pkg::QUARTER_TURN) >= rpdp_pkg::HALF_TURN) begin
      th -= rpdp_pkg::HALF_TURN; flip = 1'b1;
    end
    z = longint'(signed'(th));
    for (int i = 0; i < STEPS; i++) begin
      dx = sra(cy, i); dy = sra(cx, i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(rpdp_pkg::ATAN_TAB[i]);
      end else begin
        cx += dx; cy -= dy; z += longint'(rpdp_pkg::ATAN_TAB[i]);
      end
    end
    c = clip(sra(cx + 32768, 16), -16384, 16384);
    s = clip(sra(cy + 32768, 16), -16384, 16384);
    if (flip) begin
      c = -c; s = -s;
    end
    rot = -longint'(signed'(offy_reg)) * c + longint'(signed'(offx_reg)) * s;
    rot = clip(sra(rot + 8192, 14), -65536, 65535);
    r2 = x * x + y * y;
    dot = vx * x + vy * y;
    if (r2 > 0 && dot != 0) begin
      q = speed_quotient(dot < 0 ? -dot : dot, r2);
      rad = dot < 0 ? q : -q;
    end
    rad = clip(rad, -65536, 65535);
    r.c = 16'(c); r.s = 16'(s); r.rot = 17'(rot); r.rad = 17'(rad);
    return r;
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_rows.insert(expected_rows.size(),
                             project({range_long, range_lat, speed_long, speed_lat}));
        in_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (!pause_driver && pending_points.size() > 0 && in_gap == 0) begin
          detection_t p;
          p = pending_points.pop_front();
          range_long <= p.x; range_lat <= p.y; speed_long <= p.vx; speed_lat <= p.vy;
          in_valid <= 1'b1;
        end else begin
          if (!pause_driver && pending_points.size() > 0 && in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected word cos=%0d sin=%0d", $time, bearing_cos, bearing_sin);
          errors++;
        end else begin
          row_t e;
          e = expected_rows.pop_front();
          rows_checked++;
          if (bearing_cos !== e.c) begin
            $display("%0t: bearing_cos exp %0d got %0d", $time, e.c, bearing_cos); errors++;
          end
          if (bearing_sin !== e.s) begin
            $display("%0t: bearing_sin exp %0d got %0d", $time, e.s, bearing_sin); errors++;
          end
          if (rotation_term !== e.rot) begin
            $display("%0t: rotation_term exp %0d got %0d", $time, e.rot, rotation_term);
            errors++;
          end
          if (radial_speed !== e.rad) begin
            $display("%0t: radial_speed exp %0d got %0d", $time, e.rad, radial_speed);
            errors++;
          end
        end
      end
      if (hold_output) out_ready <= 1'b0;
      else if (out_gap > 0) begin
        out_gap--; out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(rpdp_pkg::reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rpdp_pkg::REG_YAW:      yaw_reg = val;
      rpdp_pkg::REG_OFFSET_X: offx_reg = val;
      rpdp_pkg::REG_OFFSET_Y: offy_reg = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_rows.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic add_point(int x, int y, int vx, int vy);
    detection_t p;
    p.x = 16'(x); p.y = 16'(y); p.vx = 16'(vx); p.vy = 16'(vy);
    pending_points.insert(pending_points.size(), p);
  endtask

  function automatic int rand16();
    int r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    if (r < 4) return $urandom_range(0, 600) - 300;
    return int'(signed'(16'($urandom)));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) add_point(rand16(), rand16(), rand16(), rand16());
  endtask

  initial begin
    logic [15:0] yaws[5] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000};
    logic [15:0] offs[5] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 16'hF000};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: origin, axes, field extremes, largest radial speeds
    add_point(0, 0, 0, 0);
    add_point(0, 0, 32767, -32768);
    add_point(100, 0, -500, 0);
    add_point(-100, 0, 500, 0);
    add_point(0, 100, 0, 777);
    add_point(0, -100, 0, -777);
    add_point(32767, 32767, -32768, -32768);
    add_point(-32768, -32768, 32767, 32767);
    add_point(-32768, 0, -32768, 0);
    add_point(32767, -32768, 32767, -32768);
    add_point(1, 0, -32768, 0);
    add_point(1, 1, 32767, 32767);
    add_point(-1, -1, -1, 1);
    add_point(300, 300, 100, -100);
    add_point(-5, 7, 0, 0);
    add_point(16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rpdp_pkg::REG_YAW, ph < 5 ? yaws[ph] : 16'($urandom));
      write_reg(rpdp_pkg::REG_OFFSET_X, ph < 5 ? offs[ph] : 16'($urandom));
      write_reg(rpdp_pkg::REG_OFFSET_Y, ph < 5 ? offs[(ph + 2) % 5] : 16'($urandom));
      random_phase(300);
      if (ph == 2) begin
        // long output stall while input keeps coming
        wait (expected_rows.size() > 0);
        hold_output = 1'b1;
        repeat (200) @(posedge clk);
        hold_output = 1'b0;
      end
      if (ph == 4) begin
        while (pending_points.size() > 150) @(posedge clk);
        pause_driver = 1'b1;
        while (in_valid || expected_rows.size() > 0) @(posedge clk);
        pause_driver = 1'b0;
      end
      drain();
    end

    $display("checked %0d result words over 6 mounting settings plus directed points",
             rows_checked);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
